[hw/rtl/pip_pkg.sv]
package pip_pkg;

    localparam int TALLY_W = 3;
    localparam logic [TALLY_W-1:0] MIN_VERTICES = 3'd4;

    typedef struct packed {
        logic last;
        logic few;
        logic e_main;
        logic e_close;
    } t_ctl;

endpackage

[hw/rtl/pip_edge_unit.sv]
module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en1,
    input  logic                         i_en2,
    input  logic                         i_en3,
    input  logic signed [COORD_BITS-1:0] i_ox,
    input  logic signed [COORD_BITS-1:0] i_oy,
    input  logic signed [COORD_BITS-1:0] i_nx,
    input  logic signed [COORD_BITS-1:0] i_ny,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output logic                         o_cross
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
    logic signed [DW-1:0]         n_d [4];
    logic                         n_str;
    logic signed [DW-1:0]         r_d [4];
    logic                         r_str1;

    logic [DW-1:0]         neg_d [4];
    logic [COORD_BITS-1:0] n_m [4];
    logic [COORD_BITS-1:0] r_m [4];
    logic [3:0]            r_s;
    logic                  r_str2;

    logic [PW-1:0] r_lm, r_rm;
    logic          r_ls, r_rs, r_str3;
    logic          ln, rn, less;

    // order endpoints by x, new one first on ties
    always_comb begin
        if (i_nx > i_ox) begin
            x1 = i_ox; y1 = i_oy; x2 = i_nx; y2 = i_ny;
        end else begin
            x1 = i_nx; y1 = i_ny; x2 = i_ox; y2 = i_oy;
        end
        n_str  = (i_nx < i_px) == (i_px <= i_ox);
        n_d[0] = $signed({i_py[COORD_BITS-1], i_py}) - $signed({y1[COORD_BITS-1], y1});
        n_d[1] = $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
        n_d[2] = $signed({y2[COORD_BITS-1], y2}) - $signed({y1[COORD_BITS-1], y1});
        n_d[3] = $signed({i_px[COORD_BITS-1], i_px}) - $signed({x1[COORD_BITS-1], x1});
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_d    <= n_d;
            r_str1 <= n_str;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            neg_d[k] = -r_d[k];
            n_m[k]   = r_d[k][DW-1] ? neg_d[k][COORD_BITS-1:0] : r_d[k][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_m    <= n_m;
            r_s    <= {r_d[3][DW-1], r_d[2][DW-1], r_d[1][DW-1], r_d[0][DW-1]};
            r_str2 <= r_str1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_lm   <= PW'(r_m[0]) * PW'(r_m[1]);
            r_rm   <= PW'(r_m[2]) * PW'(r_m[3]);
            r_ls   <= r_s[0] ^ r_s[1];
            r_rs   <= r_s[2] ^ r_s[3];
            r_str3 <= r_str2;
        end
    end

    always_comb begin
        ln = r_ls && (r_lm != '0);
        rn = r_rs && (r_rm != '0);
        if (ln != rn) begin
            less = ln;
        end else if (ln) begin
            less = r_lm > r_rm;
        end else begin
            less = r_lm < r_rm;
        end
        o_cross = r_str3 && less;
    end

endmodule

[hw/rtl/point_in_polygon_crossing_test_unit.sv]
// Even-odd point-in-polygon test over a stream of vertices, one vertex per request,
// the polygon's last vertex marked by tlast. The request carrying a polygon's first
// vertex also supplies the test point. A new vertex is accepted every cycle unless
// input stalls; each edge runs through a pipeline (operand difference, magnitude,
// 32x32 multiply, exact product compare); the result is registered once the last vertex
// leaves the compare. One result per polygon: tdata bit 0 is the inside flag, tuser
// bit 0 flags a polygon of fewer than four vertices (reported as outside). Input
// stalls only when a finished result waits and the pipeline behind it is full.
module point_in_polygon_crossing_test_unit
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, vertex_x, vertex_y
    input  logic [127:0]                           s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // inside_res
    output logic [7:0]                             m_axis_tdata,
    // too_few_vertices
    output logic [0:0]                             m_axis_tuser
);

    logic signed [COORD_BITS-1:0] in_px, in_py, in_vx, in_vy;
    logic signed [COORD_BITS-1:0] px_e, py_e, fx_e, fy_e;
    logic signed [COORD_BITS-1:0] r_first_vx, r_first_vy, r_prev_vx, r_prev_vy;
    logic signed [COORD_BITS-1:0] r_held_px, r_held_py;
    logic [TALLY_W-1:0]           r_tally, n_tally, tally_inc;
    logic                         acc, first_item;
    t_ctl                         n_ctl, r_ctl1, r_ctl2, r_ctl3;
    logic                         r_v1, r_v2, r_v3;
    logic                         rdy1, rdy2, rdy3, en2, en3, adv3;
    logic                         cross_main, cross_close;
    logic                         r_par, n_par;
    logic                         r_ov, r_inside, r_few;

    assign in_px = s_axis_tdata[0 +: COORD_BITS];
    assign in_py = s_axis_tdata[32 +: COORD_BITS];
    assign in_vx = s_axis_tdata[64 +: COORD_BITS];
    assign in_vy = s_axis_tdata[96 +: COORD_BITS];

    assign adv3 = r_v3 && (!r_ctl3.last || !r_ov || m_axis_tready);
    assign rdy3 = !r_v3 || adv3;
    assign en3  = r_v2 && rdy3;
    assign rdy2 = !r_v2 || rdy3;
    assign en2  = r_v1 && rdy2;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1 && i_rst_n;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign first_item    = (r_tally == '0);

    always_comb begin
        px_e      = first_item ? in_px : r_held_px;
        py_e      = first_item ? in_py : r_held_py;
        fx_e      = first_item ? in_vx : r_first_vx;
        fy_e      = first_item ? in_vy : r_first_vy;
        tally_inc = (r_tally < MIN_VERTICES) ? r_tally + 1'b1 : r_tally;
        n_tally   = s_axis_tlast ? '0 : tally_inc;
        n_ctl.last    = s_axis_tlast;
        n_ctl.few     = tally_inc < MIN_VERTICES;
        n_ctl.e_main  = !first_item;
        n_ctl.e_close = s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_prev_vx  <= in_vx;
            r_prev_vy  <= in_vy;
            r_first_vx <= fx_e;
            r_first_vy <= fy_e;
            r_held_px  <= px_e;
            r_held_py  <= py_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (acc) begin
            r_tally <= n_tally;
        end
    end

    pip_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge_main (
        .i_clk   (i_clk),
        .i_en1   (acc),
        .i_en2   (en2),
        .i_en3   (en3),
        .i_ox    (r_prev_vx),
        .i_oy    (r_prev_vy),
        .i_nx    (in_vx),
        .i_ny    (in_vy),
        .i_px    (px_e),
        .i_py    (py_e),
        .o_cross (cross_main)
    );

    pip_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge_close (
        .i_clk   (i_clk),
        .i_en1   (acc),
        .i_en2   (en2),
        .i_en3   (en3),
        .i_ox    (in_vx),
        .i_oy    (in_vy),
        .i_nx    (fx_e),
        .i_ny    (fy_e),
        .i_px    (px_e),
        .i_py    (py_e),
        .o_cross (cross_close)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= acc;
            end
            if (rdy2) begin
                r_v2 <= en2;
            end
            if (rdy3) begin
                r_v3 <= en3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ctl1 <= n_ctl;
        end
        if (en2) begin
            r_ctl2 <= r_ctl1;
        end
        if (en3) begin
            r_ctl3 <= r_ctl2;
        end
    end

    assign n_par = r_par ^ (r_ctl3.e_main && cross_main) ^ (r_ctl3.e_close && cross_close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= 1'b0;
        end else if (adv3) begin
            r_par <= r_ctl3.last ? 1'b0 : n_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv3 && r_ctl3.last) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_ctl3.last) begin
            r_inside <= n_par && !r_ctl3.few;
            r_few    <= r_ctl3.few;
        end
    end

    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = {7'b0, r_inside};
    assign m_axis_tuser[0] = r_few;

    a_few_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_few |-> !r_inside)
        else $error("too-few result reports inside");

    a_tally_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= MIN_VERTICES)
        else $error("vertex tally beyond saturation");

    a_tally_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tlast |=> r_tally == '0)
        else $error("tally not cleared after last vertex");

    a_mid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_ctl3.last |-> adv3)
        else $error("non-final vertex held at compare stage");

    a_par_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv3 && r_ctl3.last |=> !r_par)
        else $error("parity not cleared after result");

endmodule
